// ----- hdl/lcfe_pkg.sv -----
// Package for the LED color fade engine: command codes, state encoding,
// record type and blend function. No dependencies.
package lcfe_pkg;

  localparam int NUM_LEDS = 64;
  localparam logic [15:0] DEFAULT_FADE_RESET = 16'd500;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET,
    ST_START_RD,
    ST_START_WR,
    ST_UPD_RD,
    ST_UPD_CHK,
    ST_UPD_DIV,
    ST_UPD_WR,
    ST_OUT_RD,
    ST_OUT_SEND
  } state_t;

  typedef struct packed {
    logic         capture;
    logic         set_idx_in;
    logic         set_idx_zero;
    logic         idx_inc;
    logic         rd_rec;
    logic         rd_frame;
    logic         wr_frame_in;
    logic         wr_start;
    logic         div_start;
    logic         wr_update;
    logic         out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_range;
    logic active;
    logic done;
    logic div_busy;
    logic idx_last;
  } stat_t;

  function automatic logic [7:0] blend_ch(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] f);
    logic [8:0]  fp;
    logic [16:0] p;
    fp = {1'b0, f} + 9'd1;
    if (b > a) begin
      p = (b - a) * fp;
      blend_ch = a + p[15:8];
    end else begin
      p = (a - b) * fp;
      blend_ch = a - p[15:8];
    end
  endfunction

endpackage

// ----- hdl/lcfe_ctrl.sv -----
// Controller for the LED color fade engine: sequences commands, the tick
// update pass and the frame readout. Uses lcfe_pkg.
module lcfe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  lcfe_pkg::stat_t    stat,
  input  logic               out_busy,
  output lcfe_pkg::ctrl_t    ctrl
);

  lcfe_pkg::state_t state, state_next;
  logic [1:0] cmd_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcfe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    if (in_valid && in_ready) cmd_r <= cmd;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    in_ready = 1'b0;
    case (state)
      lcfe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next = lcfe_pkg::ST_SET;
        end
      end
      lcfe_pkg::ST_SET: begin
        case (cmd_r)
          lcfe_pkg::CMD_SET: begin
            if (stat.in_range) ctrl.wr_frame_in = 1'b1;
            state_next = lcfe_pkg::ST_IDLE;
          end
          lcfe_pkg::CMD_START: begin
            ctrl.set_idx_in = 1'b1;
            state_next = stat.in_range ? lcfe_pkg::ST_START_RD : lcfe_pkg::ST_IDLE;
          end
          lcfe_pkg::CMD_TICK: begin
            ctrl.set_idx_zero = 1'b1;
            state_next = lcfe_pkg::ST_UPD_RD;
          end
          default: state_next = lcfe_pkg::ST_IDLE;
        endcase
      end
      lcfe_pkg::ST_START_RD: begin
        ctrl.rd_frame = 1'b1;
        state_next = lcfe_pkg::ST_START_WR;
      end
      lcfe_pkg::ST_START_WR: begin
        ctrl.wr_start = 1'b1;
        state_next = lcfe_pkg::ST_IDLE;
      end
      lcfe_pkg::ST_UPD_RD: begin
        ctrl.rd_rec = 1'b1;
        state_next = lcfe_pkg::ST_UPD_CHK;
      end
      lcfe_pkg::ST_UPD_CHK: begin
        if (!stat.active || stat.done) begin
          if (stat.active) ctrl.wr_update = 1'b1;
          if (stat.idx_last) begin
            ctrl.set_idx_zero = 1'b1;
            state_next = lcfe_pkg::ST_OUT_RD;
          end else begin
            ctrl.idx_inc = 1'b1;
            state_next = lcfe_pkg::ST_UPD_RD;
          end
        end else begin
          ctrl.div_start = 1'b1;
          state_next = lcfe_pkg::ST_UPD_DIV;
        end
      end
      lcfe_pkg::ST_UPD_DIV: begin
        if (!stat.div_busy) state_next = lcfe_pkg::ST_UPD_WR;
      end
      lcfe_pkg::ST_UPD_WR: begin
        ctrl.wr_update = 1'b1;
        if (stat.idx_last) begin
          ctrl.set_idx_zero = 1'b1;
          state_next = lcfe_pkg::ST_OUT_RD;
        end else begin
          ctrl.idx_inc = 1'b1;
          state_next = lcfe_pkg::ST_UPD_RD;
        end
      end
      lcfe_pkg::ST_OUT_RD: begin
        ctrl.rd_frame = 1'b1;
        if (!out_busy) state_next = lcfe_pkg::ST_OUT_SEND;
      end
      lcfe_pkg::ST_OUT_SEND: begin
        ctrl.out_load = 1'b1;
        if (stat.idx_last) begin
          state_next = lcfe_pkg::ST_IDLE;
        end else begin
          ctrl.idx_inc = 1'b1;
          state_next = lcfe_pkg::ST_OUT_RD;
        end
      end
      default: state_next = lcfe_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/lcfe_dp.sv -----
// Datapath for the LED color fade engine: record memories, restoring
// divider, blend and output register. Uses lcfe_pkg.
module lcfe_dp (
  input  logic               clk,
  input  logic               rst,
  input  lcfe_pkg::ctrl_t    ctrl,
  output lcfe_pkg::stat_t    stat,
  output logic               out_busy,
  input  logic [15:0]        cfg_data,
  input  logic               cfg_we,
  input  logic [5:0]         led_index,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [15:0]        duration_ms,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_index,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               frame_last
);

  logic [23:0] frame_mem [lcfe_pkg::NUM_LEDS];
  logic [23:0] start_mem [lcfe_pkg::NUM_LEDS];
  logic [23:0] tgt_mem   [lcfe_pkg::NUM_LEDS];
  logic [31:0] time_mem  [lcfe_pkg::NUM_LEDS];
  logic [15:0] len_mem   [lcfe_pkg::NUM_LEDS];
  logic [lcfe_pkg::NUM_LEDS-1:0] active;
  logic [lcfe_pkg::NUM_LEDS-1:0] frame_ok;

  logic [15:0] default_fade;
  logic [5:0]  idx_in;
  logic [23:0] color_in;
  logic [15:0] dur_in;
  logic [31:0] now_in;
  logic [5:0]  idx;
  logic [23:0] frame_rd, start_rd, tgt_rd;
  logic [31:0] time_rd;
  logic [15:0] len_rd;
  logic [15:0] elapsed;
  logic [23:0] divq;
  logic [16:0] divr;
  logic [4:0]  div_cnt;
  logic        div_busy;
  logic [16:0] div_trial;
  logic [23:0] blended;
  logic [23:0] upd_color;

  assign elapsed = now_in[15:0] - time_rd[15:0];
  assign div_trial = {divr[15:0], divq[23]} - {1'b0, len_rd};

  always_ff @(posedge clk) begin
    if (rst) begin
      default_fade <= lcfe_pkg::DEFAULT_FADE_RESET;
      active <= '0;
      frame_ok <= '0;
      div_busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) default_fade <= cfg_data;
      if (ctrl.wr_frame_in) frame_ok[idx_in] <= 1'b1;
      if (ctrl.wr_start) active[idx] <= 1'b1;
      if (ctrl.wr_update) begin
        frame_ok[idx] <= 1'b1;
        if (stat.done) active[idx] <= 1'b0;
      end
      if (ctrl.div_start) begin
        div_busy <= 1'b1;
      end else if (div_busy && div_cnt == 5'd23) begin
        div_busy <= 1'b0;
      end
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      idx_in <= led_index;
      color_in <= {red, green, blue};
      dur_in <= duration_ms;
      now_in <= now_ms;
    end
    if (ctrl.set_idx_in) begin
      idx <= idx_in;
    end else if (ctrl.set_idx_zero) begin
      idx <= '0;
    end else if (ctrl.idx_inc) begin
      idx <= idx + 6'd1;
    end
    if (ctrl.wr_frame_in) frame_mem[idx_in] <= color_in;
    if (ctrl.wr_update) frame_mem[idx] <= upd_color;
    if (ctrl.rd_frame) frame_rd <= frame_ok[idx] ? frame_mem[idx] : 24'd0;
    if (ctrl.wr_start) begin
      start_mem[idx] <= frame_rd;
      tgt_mem[idx] <= color_in;
      time_mem[idx] <= now_in;
      len_mem[idx] <= (dur_in != 16'd0) ? dur_in : default_fade;
    end
    if (ctrl.rd_rec) begin
      start_rd <= start_mem[idx];
      tgt_rd <= tgt_mem[idx];
      time_rd <= time_mem[idx];
      len_rd <= len_mem[idx];
    end
    if (ctrl.div_start) begin
      divq <= {elapsed, 8'd0};
      divr <= '0;
      div_cnt <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + 5'd1;
      if (!div_trial[16]) begin
        divr <= div_trial;
        divq <= {divq[22:0], 1'b1};
      end else begin
        divr <= {divr[15:0], divq[23]};
        divq <= {divq[22:0], 1'b0};
      end
    end
    if (ctrl.out_load) begin
      out_index <= idx;
      {out_red, out_green, out_blue} <= frame_rd;
      frame_last <= (idx == 6'(lcfe_pkg::NUM_LEDS - 1));
    end
  end

  assign blended = {lcfe_pkg::blend_ch(start_rd[23:16], tgt_rd[23:16], divq[7:0]),
                    lcfe_pkg::blend_ch(start_rd[15:8], tgt_rd[15:8], divq[7:0]),
                    lcfe_pkg::blend_ch(start_rd[7:0], tgt_rd[7:0], divq[7:0])};
  assign upd_color = stat.done ? tgt_rd : blended;

  assign stat.in_range = ({1'b0, idx_in} < 7'(lcfe_pkg::NUM_LEDS));
  assign stat.active = active[idx];
  assign stat.done = (elapsed >= len_rd);
  assign stat.div_busy = div_busy;
  assign stat.idx_last = (idx == 6'(lcfe_pkg::NUM_LEDS - 1));
  assign out_busy = out_valid && !out_ready;

endmodule

// ----- hdl/led_color_fade_engine_top.sv -----
// Top level of the LED color fade engine: joins controller and datapath.
// Depends on lcfe_pkg, lcfe_ctrl and lcfe_dp.
//
// A tick visits each of the 64 LEDs: an idle LED is skipped, a finished
// fade takes its target color and a running fade waits for the bit-serial
// 24-bit restoring divider; then each LED is read out in turn, waiting
// while the output stalls. No clearing pass is needed after reset.
module led_color_fade_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [5:0]  led_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [15:0] duration_ms,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        frame_last
);

  lcfe_pkg::ctrl_t ctrl;
  lcfe_pkg::stat_t stat;
  logic out_busy;

  assign cfg_ready = 1'b1;

  lcfe_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .cmd, .stat, .out_busy, .ctrl
  );

  lcfe_dp u_dp (
    .clk, .rst, .ctrl, .stat, .out_busy, .cfg_data,
    .cfg_we(cfg_valid && cfg_ready),
    .led_index, .red, .green, .blue, .duration_ms, .now_ms,
    .out_valid, .out_ready, .out_index, .out_red, .out_green, .out_blue,
    .frame_last
  );

  a_last_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> out_index == 6'(lcfe_pkg::NUM_LEDS - 1))
    else $error("frame_last on wrong LED");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_index, out_red, out_green, out_blue, frame_last}))
    else $error("output word changed while waiting");

  a_div_bounded: assert property (@(posedge clk) disable iff (rst)
    u_dp.div_busy |-> u_dp.div_cnt <= 5'd23)
    else $error("divider overran");

endmodule
